// ----- rtl/imu_attitude_complementary_filter_unit_assert.svh -----
// Assertion macros for the attitude filter unit.
// Included by the modules that check their own logic; no other dependencies.
`ifndef IMU_ATTITUDE_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH
`define IMU_ATTITUDE_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IACF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IACF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IACF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IACF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/iacf_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the attitude filter.
// No dependencies.
package iacf_pkg;
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_BITS    = 5;
    localparam int WW           = 48;

    localparam logic signed [WW-1:0] HALF_TURN  = 48'sd11796480;
    localparam logic signed [WW-1:0] QUARTER    = 48'sd5898240;
    localparam logic signed [WW-1:0] CORDIC_K   = 48'sd652032875;
    localparam logic [15:0] BLEND_RESET = 16'd63570;
    localparam logic [15:0] SCALE_RESET = 16'd23488;
    localparam logic [1:0]  CFG_BLEND   = 2'd0;
    localparam logic [1:0]  CFG_SCALE   = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ATAN_R, ST_ATAN_P, ST_INC_R, ST_INC_P, ST_BW_R, ST_BA_R,
        ST_BS_R, ST_BW_P, ST_BA_P, ST_BS_P, ST_SC_R, ST_SC_P, ST_M1, ST_M2,
        ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_ATAN_H, ST_DONE
    } state_t;

    typedef enum logic [1:0] { CM_NONE, CM_VEC, CM_ROT } cmode_t;

    typedef struct packed {
        state_t st;
        logic   start;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } sts_t;

    function automatic logic signed [WW-1:0] atan_entry(input logic [STEP_BITS-1:0] i);
        case (i)
            5'd0: atan_entry = 48'sd2949120;  5'd1: atan_entry = 48'sd1740967;
            5'd2: atan_entry = 48'sd919879;   5'd3: atan_entry = 48'sd466945;
            5'd4: atan_entry = 48'sd234379;   5'd5: atan_entry = 48'sd117304;
            5'd6: atan_entry = 48'sd58666;    5'd7: atan_entry = 48'sd29335;
            5'd8: atan_entry = 48'sd14668;    5'd9: atan_entry = 48'sd7334;
            5'd10: atan_entry = 48'sd3667;    5'd11: atan_entry = 48'sd1833;
            5'd12: atan_entry = 48'sd917;     5'd13: atan_entry = 48'sd458;
            5'd14: atan_entry = 48'sd229;     5'd15: atan_entry = 48'sd115;
            5'd16: atan_entry = 48'sd57;      5'd17: atan_entry = 48'sd29;
            5'd18: atan_entry = 48'sd14;      5'd19: atan_entry = 48'sd7;
            5'd20: atan_entry = 48'sd4;       5'd21: atan_entry = 48'sd2;
            5'd22: atan_entry = 48'sd1;
            default: atan_entry = '0;
        endcase
    endfunction

    function automatic logic signed [WW-1:0] clamp_turn(input logic signed [WW-1:0] v);
        if (v < -HALF_TURN)     clamp_turn = -HALF_TURN;
        else if (v > HALF_TURN) clamp_turn = HALF_TURN;
        else                    clamp_turn = v;
    endfunction
endpackage

// ----- rtl/imu_attitude_complementary_filter_unit.sv -----
// From input transfer to result valid a sample passes five CORDIC runs (a zero vector
// skips the micro-rotations), 15 multiply and blend steps and one done step.
// One sample is in work at a time; the next is not taken until this one is done.
// The finished result sits in an output register while the next sample is taken.
// Reset (rst_n, asynchronous) clears roll and pitch state and restores default registers.
// Depends on iacf_pkg, iacf_ctrl, iacf_datapath.
module imu_attitude_complementary_filter_unit
    import iacf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [SAMPLE_BITS-1:0] accel_x, accel_y, accel_z,
    input  logic signed [SAMPLE_BITS-1:0] gyro_x, gyro_y, gyro_z,
    input  logic signed [SAMPLE_BITS-1:0] mag_x_raw, mag_y_raw, mag_z_raw,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] heading_angle,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] weight_reg, scale_reg;
    logic signed [15:0] r_reg, p_reg, h_reg, r_w, p_w, h_w;
    logic in_go, take, cdone, pend;
    cmd_t cmd;
    sts_t sts;

    // A pending register write goes first, so a sample never sees a half-applied setting.
    assign in_ready = !sts.busy && !cfg_valid;
    assign in_go = in_valid && in_ready;
    assign take = out_valid && out_ready;
    assign out_valid = pend;
    assign cfg_ready = !sts.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= BLEND_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BLEND) weight_reg <= cfg_data;
            else if (cfg_index == CFG_SCALE) scale_reg <= cfg_data;
        end
    end

    iacf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_go(in_go), .out_take(take), .cdone(cdone),
        .cmd(cmd), .sts(sts), .out_pending(pend)
    );

    iacf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cdone(cdone), .load(in_go),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y),
        .mag_x_raw(mag_x_raw), .mag_y_raw(mag_y_raw), .mag_z_raw(mag_z_raw),
        .weight(weight_reg), .scale(scale_reg),
        .roll_angle(r_w), .pitch_angle(p_w), .heading_angle(h_w)
    );

    // Results are copied into the output register when the sample finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.st == ST_DONE && (!pend || take))
        begin
            r_reg <= r_w; p_reg <= p_w; h_reg <= h_w;
        end
    end
    assign roll_angle = r_reg;
    assign pitch_angle = p_reg;
    assign heading_angle = h_reg;
endmodule

// ----- rtl/iacf_cordic.sv -----
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on iacf_pkg.
module iacf_cordic
    import iacf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cmode_t               mode,
    input  logic signed [WW-1:0] in_x,
    input  logic signed [WW-1:0] in_y,
    input  logic signed [WW-1:0] in_z,
    output logic                 done,
    output logic signed [WW-1:0] res_angle,
    output logic signed [WW-1:0] res_cos,
    output logic signed [WW-1:0] res_sin
);
    logic signed [WW-1:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic [STEP_BITS-1:0] i_reg, i_next;
    logic                 run_reg, run_next, flip_reg, flip_next, vec_reg, vec_next;
    logic                 done_reg, done_next;
    logic signed [WW-1:0] xs, ys, a, cx, cy;
    logic                 dir;

    always_comb
    begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        dir = vec_reg ? (y_reg > 0) : (z_reg < 0);
        x_next = x_reg; y_next = y_reg; z_next = z_reg; i_next = i_reg;
        run_next = run_reg; flip_next = flip_reg; vec_next = vec_reg;
        done_next = 1'b0;
        a = clamp_turn(in_z);
        if (start)
        begin
            vec_next = (mode == CM_VEC);
            i_next = '0;
            run_next = 1'b1;
            flip_next = 1'b0;
            if (mode == CM_VEC)
            begin
                z_next = '0;
                x_next = in_x;
                y_next = in_y;
                if (in_x == 0 && in_y == 0)
                begin
                    run_next = 1'b0;
                    done_next = 1'b1;
                end
                else if (in_x < 0)
                begin
                    z_next = (in_y >= 0) ? HALF_TURN : -HALF_TURN;
                    x_next = -in_x;
                    y_next = -in_y;
                end
            end
            else
            begin
                x_next = CORDIC_K;
                y_next = '0;
                z_next = a;
                if (a > QUARTER)
                begin
                    z_next = a - HALF_TURN;
                    flip_next = 1'b1;
                end
                else if (a < -QUARTER)
                begin
                    z_next = a + HALF_TURN;
                    flip_next = 1'b1;
                end
            end
        end
        else if (run_reg)
        begin
            // Vectoring drives y to zero, rotation drives z to zero.
            if (dir)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_entry(i_reg);
            end
            else
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_entry(i_reg);
            end
            if (!vec_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_entry(i_reg);
                end
                else
                begin
                    x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_entry(i_reg);
                end
            end
            i_next = i_reg + 1'b1;
            if (i_reg == STEP_BITS'(CORDIC_STEPS - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; flip_reg <= flip_next; vec_reg <= vec_next;
    end

    always_comb
    begin
        cx = flip_reg ? -x_reg : x_reg;
        cy = flip_reg ? -y_reg : y_reg;
        cx = (cx + 48'sd16384) >>> 15;
        cy = (cy + 48'sd16384) >>> 15;
        if (cx < -48'sd32768) cx = -48'sd32768; else if (cx > 48'sd32768) cx = 48'sd32768;
        if (cy < -48'sd32768) cy = -48'sd32768; else if (cy > 48'sd32768) cy = 48'sd32768;
        res_cos = cx;
        res_sin = cy;
        res_angle = clamp_turn(z_reg);
    end
    assign done = done_reg;
endmodule

// ----- rtl/iacf_datapath.sv -----
// Datapath: sample and state registers, shared multiplier and CORDIC unit.
// Depends on iacf_pkg, iacf_cordic and the assertion macro header.
`include "imu_attitude_complementary_filter_unit_assert.svh"
module iacf_datapath
    import iacf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output logic        cdone,
    input  logic        load,
    input  logic signed [SAMPLE_BITS-1:0] accel_x, accel_y, accel_z,
    input  logic signed [SAMPLE_BITS-1:0] gyro_x, gyro_y,
    input  logic signed [SAMPLE_BITS-1:0] mag_x_raw, mag_y_raw, mag_z_raw,
    input  logic [15:0] weight,
    input  logic [15:0] scale,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] heading_angle
);
    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, mx_reg, my_reg, mz_reg;
    logic signed [WW-1:0] roll_reg, pitch_reg, accr_reg, accp_reg, incr_reg, incp_reg;
    logic signed [WW-1:0] acc_reg, sr_reg, cr_reg, sp_reg, cp_reg, t_reg, hx_reg, hy_reg;
    logic signed [WW-1:0] head_reg;
    logic signed [WW-1:0] cx, cy, cz, ang, cosv, sinv, prod, blended, ap;
    logic signed [31:0] pa;
    logic signed [17:0] pb;
    logic signed [WW-1:0] axw, ayw, azw;
    cmode_t cm;
    logic signed [17:0] wgt_s, iwgt_s;

    assign axw = WW'(ax_reg) <<< 16;
    assign ayw = WW'(ay_reg) <<< 16;
    assign azw = WW'(az_reg) <<< 16;
    assign wgt_s = {2'b00, weight};
    assign iwgt_s = 18'sd65536 - wgt_s;

    always_comb
    begin
        cm = CM_NONE; cx = '0; cy = '0; cz = '0;
        case (cmd.st)
            ST_ATAN_R: begin cm = CM_VEC; cx = azw; cy = ayw; end
            ST_ATAN_P: begin cm = CM_VEC; cx = axw; cy = azw; end
            ST_SC_R:   begin cm = CM_ROT; cz = roll_reg; end
            ST_SC_P:   begin cm = CM_ROT; cz = pitch_reg; end
            ST_ATAN_H: begin cm = CM_VEC; cx = hx_reg; cy = -hy_reg; end
            default:   cm = CM_NONE;
        endcase
    end

    iacf_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cmd.start), .mode(cm),
        .in_x(cx), .in_y(cy), .in_z(cz), .done(cdone),
        .res_angle(ang), .res_cos(cosv), .res_sin(sinv)
    );

    // One shared multiplier; operands are chosen by the current step.
    always_comb
    begin
        pa = '0; pb = '0;
        case (cmd.st)
            ST_INC_R: begin pa = 32'(gx_reg); pb = 18'({1'b0, scale}); end
            ST_INC_P: begin pa = 32'(gy_reg); pb = 18'({1'b0, scale}); end
            ST_BW_R:  begin pa = 32'(roll_reg + incr_reg); pb = wgt_s; end
            ST_BA_R:  begin pa = 32'(accr_reg); pb = iwgt_s; end
            ST_BW_P:  begin pa = 32'(pitch_reg + incp_reg); pb = wgt_s; end
            ST_BA_P:  begin pa = 32'(accp_reg); pb = iwgt_s; end
            ST_M1:    begin pa = 32'(my_reg); pb = 18'(sr_reg); end
            ST_M2:    begin pa = 32'(mz_reg); pb = 18'(cr_reg); end
            ST_M3:    begin pa = 32'(mx_reg); pb = 18'(cp_reg); end
            ST_M4:    begin pa = 32'(t_reg >>> 15); pb = 18'(sp_reg); end
            ST_M5:    begin pa = 32'(my_reg); pb = 18'(cr_reg); end
            ST_M6:    begin pa = 32'(mz_reg); pb = 18'(sr_reg); end
            default:  begin pa = '0; pb = '0; end
        endcase
        prod = WW'(pa * pb);
        blended = clamp_turn(acc_reg >>> 16);
        ap = ang - QUARTER;
        if (ap <= -HALF_TURN) ap = ap + (HALF_TURN <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg <= '0;
            pitch_reg <= '0;
        end
        else if (cmd.st == ST_BS_R)
            roll_reg <= blended;
        else if (cmd.st == ST_BS_P)
            pitch_reg <= blended;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
            gx_reg <= gyro_x; gy_reg <= gyro_y;
            mx_reg <= mag_x_raw; my_reg <= mag_y_raw; mz_reg <= mag_z_raw;
        end
        case (cmd.st)
            ST_ATAN_R: if (cdone) accr_reg <= ang;
            ST_ATAN_P: if (cdone) accp_reg <= ap;
            ST_INC_R:  incr_reg <= prod >>> 8;
            ST_INC_P:  incp_reg <= prod >>> 8;
            ST_BW_R, ST_BW_P: acc_reg <= prod;
            ST_BA_R, ST_BA_P: acc_reg <= acc_reg + prod;
            ST_SC_R:   if (cdone) begin sr_reg <= sinv; cr_reg <= cosv; end
            ST_SC_P:   if (cdone) begin sp_reg <= sinv; cp_reg <= cosv; end
            ST_M1:     t_reg <= prod;
            ST_M2:     t_reg <= t_reg + prod;
            ST_M3:     hx_reg <= prod;
            ST_M4:     hx_reg <= hx_reg + prod;
            ST_M5:     hy_reg <= prod;
            ST_M6:     hy_reg <= hy_reg - prod;
            ST_ATAN_H: if (cdone) head_reg <= ang;
            default:   ;
        endcase
    end

    assign roll_angle = roll_reg[24:9];
    assign pitch_angle = pitch_reg[24:9];
    assign heading_angle = head_reg[24:9];

    `IACF_ASSERT_IMP(a_roll_sat, clk, rst_n, 1'b1, (roll_reg <= HALF_TURN) && (roll_reg >= -HALF_TURN))
    `IACF_ASSERT_IMP(a_pitch_sat, clk, rst_n, 1'b1, (pitch_reg <= HALF_TURN) && (pitch_reg >= -HALF_TURN))
    `IACF_ASSERT_NXT(a_roll_hold, clk, rst_n, cmd.st != ST_BS_R, $stable(roll_reg))
endmodule

// ----- rtl/iacf_ctrl.sv -----
// Sequencer for the attitude filter: steps the datapath through one sample.
// Depends on iacf_pkg and the assertion macro header.
`include "imu_attitude_complementary_filter_unit_assert.svh"
module iacf_ctrl
    import iacf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_go,
    input  logic out_take,
    input  logic cdone,
    output cmd_t cmd,
    output sts_t sts,
    output logic out_pending
);
    state_t state_reg, state_next;
    logic   first_reg, first_next, pend_reg, pend_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        case (state_reg)
            ST_IDLE:   if (in_go) begin state_next = ST_ATAN_R; first_next = 1'b1; end
            ST_ATAN_R: if (cdone) begin state_next = ST_ATAN_P; first_next = 1'b1; end
            ST_ATAN_P: if (cdone) state_next = ST_INC_R;
            ST_INC_R:  state_next = ST_INC_P;
            ST_INC_P:  state_next = ST_BW_R;
            ST_BW_R:   state_next = ST_BA_R;
            ST_BA_R:   state_next = ST_BS_R;
            ST_BS_R:   state_next = ST_BW_P;
            ST_BW_P:   state_next = ST_BA_P;
            ST_BA_P:   state_next = ST_BS_P;
            ST_BS_P:   begin state_next = ST_SC_R; first_next = 1'b1; end
            ST_SC_R:   if (cdone) begin state_next = ST_SC_P; first_next = 1'b1; end
            ST_SC_P:   if (cdone) state_next = ST_M1;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_M4;
            ST_M4:     state_next = ST_M5;
            ST_M5:     state_next = ST_M6;
            ST_M6:     state_next = ST_M7;
            ST_M7:     begin state_next = ST_ATAN_H; first_next = 1'b1; end
            ST_ATAN_H: if (cdone) state_next = ST_DONE;
            ST_DONE:   if (!pend_reg || out_take) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (out_take) pend_next = 1'b0;
        if (state_reg == ST_DONE && (!pend_reg || out_take)) pend_next = 1'b1;
    end

    always_comb
    begin
        cmd.st = state_reg;
        cmd.start = first_reg;
        sts.busy = (state_reg != ST_IDLE);
        out_pending = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            pend_reg <= pend_next;
        end
    end

    `IACF_ASSERT_IMP(a_go_idle, clk, rst_n, in_go, state_reg == ST_IDLE)
    `IACF_ASSERT_NXT(a_done_pend, clk, rst_n, state_reg == ST_DONE && state_next == ST_IDLE, pend_reg)
    `IACF_ASSERT_IMP(a_start_cordic, clk, rst_n, first_reg, state_reg == ST_ATAN_R || state_reg == ST_ATAN_P || state_reg == ST_SC_R || state_reg == ST_SC_P || state_reg == ST_ATAN_H)
endmodule
